>>> rtl/vars_pkg.sv
`default_nettype none
package vars_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned CfgAddrW = 4;

  // register indexes
  localparam logic [1:0] RegMode = 2'd0;
  localparam logic [1:0] RegAngle = 2'd1;
  localparam logic [1:0] RegScale = 2'd2;

  // transform modes
  localparam logic [1:0] ModeRotX = 2'd0;
  localparam logic [1:0] ModeRotY = 2'd1;
  localparam logic [1:0] ModeRotZ = 2'd2;
  localparam logic [1:0] ModeScale = 2'd3;

  localparam logic signed [31:0] ScaleReset = 32'sd65536;
  localparam logic signed [31:0] UnitQ16 = 32'sd65536;

  // sine and cosine of the configured angle, with a settled flag
  typedef struct packed {
    logic ready;
    logic signed [17:0] sin;
    logic signed [17:0] cos;
  } trig_t;

endpackage
`default_nettype wire

>>> rtl/vars_sincos.sv
`default_nettype none
module vars_sincos
  import vars_pkg::*;
(
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start_i,
  input  wire signed [17:0] angle_i,
  output trig_t             trig_o
);

  localparam logic signed [18:0] FullTurn = 19'sd92160;
  localparam logic [16:0] QuarterTurn = 17'd23040;
  localparam logic [16:0] EighthTurn = 17'd11520;
  localparam logic [30:0] OneQ30 = 31'd1073741824;
  // pi in q2.30 split as 46080 * PiWhole + PiFrac, so the radian conversion
  // only divides a small remainder by 46080 = 1024 * 45
  localparam logic [16:0] PiWhole = 17'd73204;
  localparam logic [14:0] PiFrac = 15'd19106;
  localparam logic [18:0] Recip45 = 19'd372828;  // ceil(2^24 / 45)

  // floor(p / d) for p below 2^30 is (p * ceil(2^k / d)) >> k, k = 30 + ceil(log2 d)
  localparam logic [30:0] RecipS110 = 31'(((64'd1 << 37) + 64'd109) / 64'd110);
  localparam logic [30:0] RecipS72 = 31'(((64'd1 << 37) + 64'd71) / 64'd72);
  localparam logic [30:0] RecipS42 = 31'(((64'd1 << 36) + 64'd41) / 64'd42);
  localparam logic [30:0] RecipS20 = 31'(((64'd1 << 35) + 64'd19) / 64'd20);
  localparam logic [30:0] RecipS6 = 31'(((64'd1 << 33) + 64'd5) / 64'd6);
  localparam logic [30:0] RecipC132 = 31'(((64'd1 << 38) + 64'd131) / 64'd132);
  localparam logic [30:0] RecipC90 = 31'(((64'd1 << 37) + 64'd89) / 64'd90);
  localparam logic [30:0] RecipC56 = 31'(((64'd1 << 36) + 64'd55) / 64'd56);
  localparam logic [30:0] RecipC30 = 31'(((64'd1 << 35) + 64'd29) / 64'd30);
  localparam logic [30:0] RecipC12 = 31'(((64'd1 << 34) + 64'd11) / 64'd12);
  localparam logic [30:0] RecipC2 = 31'(((64'd1 << 31) + 64'd1) / 64'd2);

  typedef enum logic [3:0] {
    ST_IDLE, ST_RANGE, ST_XMUL, ST_XDIV, ST_X2, ST_HMUL, ST_HDIV, ST_HUPD, ST_FIN
  } state_e;

  function automatic logic [30:0] series_recip(input logic cos_phase, input logic [2:0] idx);
    logic [30:0] m;
    m = RecipS110;
    if (!cos_phase) begin
      case (idx)
        3'd0: m = RecipS110;
        3'd1: m = RecipS72;
        3'd2: m = RecipS42;
        3'd3: m = RecipS20;
        3'd4: m = RecipS6;
        default: m = RecipS110;
      endcase
    end else begin
      case (idx)
        3'd0: m = RecipC132;
        3'd1: m = RecipC90;
        3'd2: m = RecipC56;
        3'd3: m = RecipC30;
        3'd4: m = RecipC12;
        3'd5: m = RecipC2;
        default: m = RecipC132;
      endcase
    end
    return m;
  endfunction

  function automatic logic [5:0] series_shift(input logic cos_phase, input logic [2:0] idx);
    logic [5:0] k;
    k = 6'd37;
    if (!cos_phase) begin
      case (idx)
        3'd0: k = 6'd37;
        3'd1: k = 6'd37;
        3'd2: k = 6'd36;
        3'd3: k = 6'd35;
        3'd4: k = 6'd33;
        default: k = 6'd37;
      endcase
    end else begin
      case (idx)
        3'd0: k = 6'd38;
        3'd1: k = 6'd37;
        3'd2: k = 6'd36;
        3'd3: k = 6'd35;
        3'd4: k = 6'd34;
        3'd5: k = 6'd31;
        default: k = 6'd38;
      endcase
    end
    return k;
  endfunction

  state_e state_q;
  logic [13:0] t_q;
  logic [1:0] quad_q;
  logic swap_q;
  logic [30:0] whole_q;
  logic [27:0] n_q;
  logic [29:0] x_q;
  logic [29:0] x2_q;
  logic [29:0] p_q;
  logic [29:0] q_q;
  logic [30:0] h_q;
  logic [2:0] idx_q;
  logic cphase_q;
  logic [16:0] os_q;
  logic signed [17:0] sin_q, cos_q;

  // angle reduction into one turn and quadrant split; the octant fold follows in ST_RANGE
  logic signed [18:0] a0, a1, a2;
  logic [16:0] a_u, rq;
  logic [1:0] quad;
  assign a0 = 19'(angle_i);
  assign a1 = (a0 < 0) ? a0 + FullTurn : ((a0 >= FullTurn) ? a0 - FullTurn : a0);
  assign a2 = (a1 < 0) ? a1 + FullTurn : a1;
  assign a_u = a2[16:0];
  always_comb begin
    if (a_u >= 17'd69120) begin
      quad = 2'd3;
      rq = a_u - 17'd69120;
    end else if (a_u >= 17'd46080) begin
      quad = 2'd2;
      rq = a_u - 17'd46080;
    end else if (a_u >= QuarterTurn) begin
      quad = 2'd1;
      rq = a_u - QuarterTurn;
    end else begin
      quad = 2'd0;
      rq = a_u;
    end
  end

  // radian conversion: x = t * PiWhole + floor((t * PiFrac + 23040) / 46080)
  logic [30:0] t_whole;
  logic [27:0] t_frac;
  logic [36:0] frac_m;
  assign t_whole = t_q * PiWhole;
  assign t_frac = t_q * PiFrac + 28'(QuarterTurn);
  assign frac_m = n_q[27:10] * Recip45;

  logic [59:0] xx;
  logic [60:0] x2h, xh, qprod;
  logic [31:0] s_rnd, c_rnd;
  logic [16:0] oct_s, oct_c;
  logic signed [17:0] ps, pc;
  assign xx = x_q * x_q;
  assign x2h = x2_q * h_q;
  assign xh = x_q * h_q;
  assign qprod = p_q * series_recip(cphase_q, idx_q);
  assign s_rnd = {1'b0, xh[60:30]} + 32'd8192;
  assign c_rnd = {1'b0, h_q} + 32'd8192;
  assign oct_s = os_q;
  assign oct_c = c_rnd[30:14];
  assign ps = swap_q ? $signed({1'b0, oct_c}) : $signed({1'b0, oct_s});
  assign pc = swap_q ? $signed({1'b0, oct_s}) : $signed({1'b0, oct_c});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RANGE;
      sin_q <= '0;
      cos_q <= '0;
    end else if (start_i) begin
      state_q <= ST_RANGE;
    end else begin
      case (state_q)
        ST_IDLE: ;
        ST_RANGE: begin
          quad_q <= quad;
          swap_q <= (rq > EighthTurn);
          t_q <= (rq > EighthTurn) ? 14'(QuarterTurn - rq) : rq[13:0];
          state_q <= ST_XMUL;
        end
        ST_XMUL: begin
          whole_q <= t_whole;
          n_q <= t_frac;
          state_q <= ST_XDIV;
        end
        ST_XDIV: begin
          x_q <= 30'(whole_q + 31'(frac_m[36:24]));
          state_q <= ST_X2;
        end
        ST_X2: begin
          x2_q <= xx[59:30];
          h_q <= OneQ30;
          idx_q <= '0;
          cphase_q <= 1'b0;
          state_q <= ST_HMUL;
        end
        ST_HMUL: begin
          p_q <= x2h[59:30];
          state_q <= ST_HDIV;
        end
        ST_HDIV: begin
          q_q <= 30'(qprod >> series_shift(cphase_q, idx_q));
          state_q <= ST_HUPD;
        end
        ST_HUPD: begin
          h_q <= OneQ30 - {1'b0, q_q};
          idx_q <= idx_q + 3'd1;
          if ((!cphase_q && idx_q == 3'd4) || (cphase_q && idx_q == 3'd5)) state_q <= ST_FIN;
          else state_q <= ST_HMUL;
        end
        ST_FIN: begin
          if (!cphase_q) begin
            os_q <= s_rnd[30:14];
            cphase_q <= 1'b1;
            h_q <= OneQ30;
            idx_q <= '0;
            state_q <= ST_HMUL;
          end else begin
            case (quad_q)
              2'd0: begin sin_q <= ps; cos_q <= pc; end
              2'd1: begin sin_q <= pc; cos_q <= -ps; end
              2'd2: begin sin_q <= -ps; cos_q <= -pc; end
              default: begin sin_q <= -pc; cos_q <= ps; end
            endcase
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign trig_o.ready = (state_q == ST_IDLE);
  assign trig_o.sin = sin_q;
  assign trig_o.cos = cos_q;

endmodule
`default_nettype wire

>>> rtl/vars_pipe.sv
`default_nettype none
module vars_pipe
  import vars_pkg::*;
(
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               en_i,
  input  wire               valid_i,
  input  wire        [95:0] vert_i,
  input  wire         [1:0] mode_i,
  input  wire signed [31:0] scale_i,
  input  trig_t             trig_i,
  output logic              valid_o,
  output logic       [95:0] vert_o
);

  function automatic logic [31:0] round_sat(input logic signed [64:0] v);
    logic signed [65:0] t;
    logic signed [49:0] r;
    logic [31:0] res;
    t = 66'(v) + 66'sd32768;
    r = 50'(t >>> 16);
    if (r > 50'sd2147483647) res = 32'h7fff_ffff;
    else if (r < -50'sd2147483648) res = 32'h8000_0000;
    else res = r[31:0];
    return res;
  endfunction

  logic [3:0] v_q;
  logic signed [31:0] coef_q [3][2];
  logic signed [31:0] opnd_q [3][2];
  logic signed [63:0] prod_q [3][2];
  logic signed [64:0] sum_q [3];
  logic [95:0] out_q;

  logic signed [31:0] x, y, z, s, c, ns, one, sf;
  logic signed [31:0] coef_d [3][2];
  logic signed [31:0] opnd_d [3][2];
  assign x = vert_i[31:0];
  assign y = vert_i[63:32];
  assign z = vert_i[95:64];
  assign s = 32'(trig_i.sin);
  assign c = 32'(trig_i.cos);
  assign ns = -s;
  assign one = UnitQ16;
  assign sf = (scale_i > 0) ? scale_i : UnitQ16;

  // each output coordinate is coef0 * opnd0 + coef1 * opnd1
  always_comb begin
    coef_d[0][0] = one; opnd_d[0][0] = x; coef_d[0][1] = '0; opnd_d[0][1] = '0;
    coef_d[1][0] = one; opnd_d[1][0] = y; coef_d[1][1] = '0; opnd_d[1][1] = '0;
    coef_d[2][0] = one; opnd_d[2][0] = z; coef_d[2][1] = '0; opnd_d[2][1] = '0;
    case (mode_i)
      ModeRotX: begin
        coef_d[1][0] = c; coef_d[1][1] = ns; opnd_d[1][1] = z;
        coef_d[2][0] = s; opnd_d[2][0] = y; coef_d[2][1] = c; opnd_d[2][1] = z;
      end
      ModeRotY: begin
        coef_d[0][0] = c; coef_d[0][1] = s; opnd_d[0][1] = z;
        coef_d[2][0] = c; coef_d[2][1] = ns; opnd_d[2][1] = x;
      end
      ModeRotZ: begin
        coef_d[0][0] = c; coef_d[0][1] = ns; opnd_d[0][1] = y;
        coef_d[1][0] = s; opnd_d[1][0] = x; coef_d[1][1] = c; opnd_d[1][1] = y;
      end
      default: begin
        coef_d[0][0] = sf; coef_d[1][0] = sf; coef_d[2][0] = sf;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (en_i) v_q <= {v_q[2:0], valid_i};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 2; j++) begin
          coef_q[i][j] <= coef_d[i][j];
          opnd_q[i][j] <= opnd_d[i][j];
          prod_q[i][j] <= coef_q[i][j] * opnd_q[i][j];
        end
        sum_q[i] <= 65'(prod_q[i][0]) + 65'(prod_q[i][1]);
        out_q[32*i +: 32] <= round_sat(sum_q[i]);
      end
    end
  end

  assign valid_o = v_q[3];
  assign vert_o = out_q;

endmodule
`default_nettype wire

>>> rtl/vertex_axis_rotate_scale_core.sv
// vertex rotate / scale stream core
// slave stream s_axis_* carries one vertex per transaction (x, y, z, signed q16.16);
// master stream m_axis_* returns the transformed vertex, rounded and saturated.
// the apb port holds mode (0x0), angle in 1/256 degree (0x4) and scale factor (0x8).
// throughput: one vertex per cycle through the four-stage multiply/add pipeline while
// the receiver is not stalling and the sine/cosine unit has settled.
// an angle write starts the sine/cosine unit; it runs the radian conversion,
// then per series term the multiply, the reciprocal multiply for the constant
// divide and the update, then rounds each of sine and cosine, and
// s_axis_tready stays low until it has settled.
// after reset the same sine/cosine pass runs for the reset angle before the
// first vertex is taken; the pipeline comes out of reset empty.
// when the receiver stalls the whole pipeline holds: no transaction is lost
// or repeated, and s_axis_tready drops while a stalled output transaction waits.
// configuration is meant to be written only while the stream is idle.
`default_nettype none
module vertex_axis_rotate_scale_core
  import vars_pkg::*;
(
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire         [95:0] s_axis_tdata,  // x_in, y_in, z_in
  output logic               m_axis_tvalid,
  input  wire                m_axis_tready,
  output logic        [95:0] m_axis_tdata,  // x_out, y_out, z_out
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire [CfgAddrW-1:0] paddr,
  input  wire         [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready
);

  logic [1:0] mode_q;
  logic signed [17:0] angle_q;
  logic signed [31:0] scale_q;
  logic wr;
  logic [1:0] reg_idx;
  trig_t trig;
  logic pipe_en;

  assign pready = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeRotX;
      angle_q <= '0;
      scale_q <= ScaleReset;
    end else if (wr) begin
      case (reg_idx)
        RegMode: mode_q <= pwdata[1:0];
        RegAngle: angle_q <= pwdata[17:0];
        RegScale: scale_q <= pwdata;
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      RegMode: prdata = {30'd0, mode_q};
      RegAngle: prdata = 32'(angle_q);
      RegScale: prdata = scale_q;
      default: prdata = '0;
    endcase
  end

  vars_sincos u_sincos (
    .clk_i,
    .rst_ni,
    .start_i(wr && reg_idx == RegAngle),
    .angle_i(angle_q),
    .trig_o(trig)
  );

  // the pipeline advances whenever the output register is free or drained
  assign pipe_en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = pipe_en && trig.ready;

  vars_pipe u_pipe (
    .clk_i,
    .rst_ni,
    .en_i(pipe_en),
    .valid_i(s_axis_tvalid && s_axis_tready),
    .vert_i(s_axis_tdata),
    .mode_i(mode_q),
    .scale_i(scale_q),
    .trig_i(trig),
    .valid_o(m_axis_tvalid),
    .vert_o(m_axis_tdata)
  );

endmodule
`default_nettype wire

>>> rtl/vars_checker.sv
`default_nettype none
module vars_checker
  import vars_pkg::*;
(
  input wire                clk_i,
  input wire                rst_ni,
  input wire                s_axis_tready,
  input wire                m_axis_tvalid,
  input wire                m_axis_tready,
  input wire         [95:0] m_axis_tdata,
  input wire                psel,
  input wire                penable,
  input wire                pwrite,
  input wire [CfgAddrW-1:0] paddr,
  input wire                pready
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output data changed while stalled");

  a_angle_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && paddr[3:2] == RegAngle |=> !s_axis_tready)
    else $error("input taken while trig unit recomputes");

  a_stall_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while output stalled");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind vertex_axis_rotate_scale_core vars_checker u_vars_checker (
  .clk_i,
  .rst_ni,
  .s_axis_tready,
  .m_axis_tvalid,
  .m_axis_tready,
  .m_axis_tdata,
  .psel,
  .penable,
  .pwrite,
  .paddr,
  .pready
);
`default_nettype wire
